### rtl/lpcd_pkg.sv
// Shared constants and types of the page cache directory.
`timescale 1ns / 1ps
package lpcd_pkg;

  // Geometry of the directory.
  localparam int unsigned SLOTS     = 64;
  localparam int unsigned PAGE_BITS = 40;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W     = $clog2(SLOTS + 1);

  // Configuration port.
  localparam int unsigned LIMIT_W     = 7;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
  localparam logic [PADDR_W-1:0] ADDR_SLOT_LIMIT = PADDR_W'(0);

  // Input action codes.
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // Contents of one cell of the recency chain.
  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] tag;
    logic [SLOT_W-1:0]    slot;
  } entry_t;

  // Update command from the controller to the chain.
  typedef struct packed {
    logic                 update;
    logic [SLOT_W-1:0]    pos;
    logic [PAGE_BITS-1:0] new_tag;
    logic [SLOT_W-1:0]    new_slot;
  } chain_cmd_t;

  // Search results from the chain to the controller.
  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    hit_pos;
    logic [SLOT_W-1:0]    hit_slot;
    logic [PAGE_BITS-1:0] tail_tag;
    logic [SLOT_W-1:0]    tail_slot;
  } chain_stat_t;

endpackage

### rtl/lru_page_cache_directory.sv
// Top level of the fully associative page cache directory with LRU replacement.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  in        input      in_valid_i / in_stall_o   action_i, page_number_i
//  out       output     out_valid_o / out_stall_i hit_o, slot_index_o, evicted_o,
//                                                 evicted_page_o
//  config    input      APB (psel/penable/pwrite) slot_limit at byte address 0
//
//  Each transaction passes a search state, comparing the key against every cell
//  in parallel, and an update state, shifting the recency chain and loading the
//  output register. The rate is set by that compare and update pair of the chain.
//  A stalled output holds the update cycle until the result register is free.
//  Reset clears every valid mark, the use count and the control state, and sets
//  the slot limit to 64; no clearing pass is needed.
module lru_page_cache_directory (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [lpcd_pkg::PAGE_BITS-1:0] page_number_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic [lpcd_pkg::SLOT_W-1:0]    slot_index_o,
  output logic                           evicted_o,
  output logic [lpcd_pkg::PAGE_BITS-1:0] evicted_page_o,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpcd_pkg::PADDR_W-1:0]   paddr,
  input  logic [lpcd_pkg::PDATA_W-1:0]   pwdata,
  output logic [lpcd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import lpcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  state_e               state_q;
  logic                 action_q;
  logic [PAGE_BITS-1:0] key_q;
  logic [CNT_W-1:0]     used_q;
  logic [LIMIT_W-1:0]   limit_q;
  chain_stat_t          stat;
  chain_stat_t          stat_q;
  chain_cmd_t           cmd;

  logic                 out_valid_q;
  logic                 hit_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 evicted_q;
  logic [PAGE_BITS-1:0] evicted_page_q;

  logic                 accept;
  logic                 can_write;
  logic                 finish;
  logic [CMP_W-1:0]     limit_ext;
  logic [CMP_W-1:0]     eff_limit;
  logic                 has_free;
  logic                 evict;

  // Configuration register. Writes should happen only while the block is idle; the block itself does not enforce this.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SLOT_LIMIT) ? PDATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_SLOT_LIMIT)) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // A limit of zero behaves as one, and one above the slot count as the slot count.
  always_comb begin
    limit_ext = CMP_W'(limit_q);
    if (limit_ext == '0) begin
      eff_limit = CMP_W'(1);
    end else if (limit_ext > CMP_W'(SLOTS)) begin
      eff_limit = CMP_W'(SLOTS);
    end else begin
      eff_limit = limit_ext;
    end
    has_free = CMP_W'(used_q) < eff_limit;
  end

  // The result register may be loaded when empty or when its result leaves now.
  assign can_write  = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == ST_UPDATE) && can_write;
  assign in_stall_o = !((state_q == ST_IDLE) || finish);
  assign accept     = in_valid_i && !in_stall_o;

  // An insert that misses with no slot free replaces the tail entry.
  assign evict = !stat_q.hit && (action_q == ACT_INSERT) && !has_free;

  // Decide how the chain moves. A hit or an eviction moves the touched entry to
  // the front; an insert into a free slot pushes every valid entry back by one
  // and the lowest free slot, which is always the use count, enters at the front.
  always_comb begin
    cmd          = '0;
    cmd.new_tag  = key_q;
    if (stat_q.hit) begin
      cmd.update   = finish;
      cmd.pos      = stat_q.hit_pos;
      cmd.new_slot = stat_q.hit_slot;
    end else if (action_q == ACT_INSERT) begin
      cmd.update = finish;
      if (has_free) begin
        cmd.pos      = used_q[SLOT_W-1:0];
        cmd.new_slot = used_q[SLOT_W-1:0];
      end else begin
        cmd.pos      = SLOT_W'(used_q - CNT_W'(1));
        cmd.new_slot = stat_q.tail_slot;
      end
    end
  end

  lpcd_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_q),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      action_q       <= ACT_LOOKUP;
      key_q          <= '0;
      used_q         <= '0;
      stat_q         <= '0;
      out_valid_q    <= 1'b0;
      hit_q          <= 1'b0;
      slot_q         <= '0;
      evicted_q      <= 1'b0;
      evicted_page_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          stat_q  <= stat;
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (finish) begin
            hit_q          <= stat_q.hit;
            // The chain command carries slot zero for a lookup that misses.
            slot_q         <= cmd.new_slot;
            evicted_q      <= evict;
            evicted_page_q <= evict ? stat_q.tail_tag : '0;
            if (!stat_q.hit && (action_q == ACT_INSERT) && has_free) begin
              used_q <= used_q + CNT_W'(1);
            end
            state_q <= accept ? ST_SEARCH : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        action_q <= action_i;
        key_q    <= page_number_i;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign slot_index_o   = slot_q;
  assign evicted_o      = evicted_q;
  assign evicted_page_o = evicted_page_q;

endmodule

### rtl/lpcd_cell.sv
// One cell of the recency chain: holds one entry and compares it with the key.
`timescale 1ns / 1ps
module lpcd_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  lpcd_pkg::entry_t              entry_i,
  input  logic [lpcd_pkg::PAGE_BITS-1:0] key_i,
  output lpcd_pkg::entry_t              entry_o,
  output logic                          match_o
);
  import lpcd_pkg::*;

  logic                 valid_q;
  logic [PAGE_BITS-1:0] tag_q;
  logic [SLOT_W-1:0]    slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tag_q  <= entry_i.tag;
      slot_q <= entry_i.slot;
    end
  end

  assign entry_o = '{valid: valid_q, tag: tag_q, slot: slot_q};
  assign match_o = valid_q && (tag_q == key_i);

endmodule

### rtl/lpcd_chain.sv
// Row of recency cells, most recent at position zero, with hit and tail reduction.
`timescale 1ns / 1ps
module lpcd_chain (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lpcd_pkg::PAGE_BITS-1:0] key_i,
  input  lpcd_pkg::chain_cmd_t           cmd_i,
  output lpcd_pkg::chain_stat_t          stat_o
);
  import lpcd_pkg::*;

  entry_t            entry_in [SLOTS];
  entry_t            entry_out[SLOTS];
  logic [SLOTS-1:0]  load;
  logic [SLOTS-1:0]  match;
  logic [SLOTS-1:0]  tail;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign entry_in[i] = '{valid: 1'b1, tag: cmd_i.new_tag, slot: cmd_i.new_slot};
      assign tail[i]     = entry_out[i].valid && !entry_out[i+1].valid;
    end else if (i == SLOTS - 1) begin : g_last
      assign entry_in[i] = entry_out[i-1];
      assign tail[i]     = entry_out[i].valid;
    end else begin : g_mid
      assign entry_in[i] = entry_out[i-1];
      assign tail[i]     = entry_out[i].valid && !entry_out[i+1].valid;
    end

    // Cells up to the touched position shift one place towards the old end.
    assign load[i] = cmd_i.update && (SLOT_W'(i) <= cmd_i.pos);

    lpcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load[i]),
      .entry_i (entry_in[i]),
      .key_i   (key_i),
      .entry_o (entry_out[i]),
      .match_o (match[i])
    );
  end

  // Tags of valid cells are unique, so at most one match; the tail is one-hot too.
  always_comb begin
    stat_o = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (match[i]) begin
        stat_o.hit      = 1'b1;
        stat_o.hit_pos  = stat_o.hit_pos | SLOT_W'(i);
        stat_o.hit_slot = stat_o.hit_slot | entry_out[i].slot;
      end
      if (tail[i]) begin
        stat_o.tail_tag  = stat_o.tail_tag | entry_out[i].tag;
        stat_o.tail_slot = stat_o.tail_slot | entry_out[i].slot;
      end
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the LRU page cache directory: directed table, then random phases.
module tb;
  import lpcd_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned TIMEOUT_NS    = 3_000_000;
  localparam int unsigned DRAIN_CYCLES  = 5000;
  localparam int unsigned SETTLE_CYCLES = 6;

  // One directory answer, laid out in port order.
  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted;
    logic [PAGE_BITS-1:0] victim;
  } dir_result_t;

  // A row of the directed table is either a page access or a write of the slot limit.
  typedef enum logic {ROW_ACCESS, ROW_LIMIT} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic                 act;
    logic [PAGE_BITS-1:0] page;
    logic [PDATA_W-1:0]   wdata;
    logic                 fixed;
    dir_result_t          want;
  } stim_row_t;

  // Patterns for the result side back-pressure.
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_TOGGLE, STALL_HEAVY} stall_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 action_i;
  logic [PAGE_BITS-1:0] page_number_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 hit_o;
  logic [SLOT_W-1:0]    slot_index_o;
  logic                 evicted_o;
  logic [PAGE_BITS-1:0] evicted_page_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Mirror of the directory: tags, valid marks, recency ranks, use count and limit.
  logic [PAGE_BITS-1:0] tag_mirror [SLOTS];
  bit                   resident   [SLOTS];
  int unsigned          age        [SLOTS];
  int unsigned          occupancy;
  logic [LIMIT_W-1:0]   limit_mirror;

  dir_result_t          expected_q [$];
  int unsigned          mismatches;
  int unsigned          burst_left;

  lru_page_cache_directory u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .page_number_i  (page_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .slot_index_o   (slot_index_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // A watchdog in case the block locks up or never drains.
  initial begin
    #(TIMEOUT_NS);
    $display("lru_page_cache_directory test failed");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // The limit register holds seven bits; zero behaves as one slot and anything above the
  // slot count behaves as the full directory.
  function automatic int unsigned effective_limit();
    if (limit_mirror == '0) return 1;
    if (int'(limit_mirror) > int'(SLOTS)) return SLOTS;
    return int'(limit_mirror);
  endfunction

  // Promote a valid slot to most recent; every slot that was younger ages by one.
  function automatic void make_recent(int s);
    int unsigned old;
    old = age[s];
    for (int i = 0; i < int'(SLOTS); i++)
      if (resident[i] && age[i] < old) age[i]++;
    age[s] = 0;
  endfunction

  // Work out the answer to one access and move the mirror on by that access.
  function automatic dir_result_t predict_access(logic act, logic [PAGE_BITS-1:0] page);
    dir_result_t res;
    int          found;
    int          spare;
    int          oldest;
    int unsigned oldest_age;
    res        = '0;
    found      = -1;
    spare      = -1;
    oldest     = -1;
    oldest_age = 0;
    for (int i = 0; i < int'(SLOTS); i++)
      if (found < 0 && resident[i] && tag_mirror[i] == page) found = i;
    if (found >= 0) begin
      // Hits refresh the slot, whether from a lookup or from a resident insert.
      make_recent(found);
      res.hit  = 1'b1;
      res.slot = SLOT_W'(found);
    end else if (act == ACT_INSERT) begin
      if (occupancy < effective_limit()) begin
        for (int i = 0; i < int'(SLOTS); i++)
          if (spare < 0 && !resident[i]) spare = i;
      end
      if (spare >= 0) begin
        // A new page in the lowest free slot; all resident pages get one step older.
        for (int i = 0; i < int'(SLOTS); i++)
          if (resident[i]) age[i]++;
        resident[spare]   = 1'b1;
        tag_mirror[spare] = page;
        age[spare]        = 0;
        occupancy++;
        res.slot = SLOT_W'(spare);
      end else begin
        // Replacement: the lowest numbered slot of the highest rank is the victim.
        for (int i = 0; i < int'(SLOTS); i++) begin
          if (resident[i] && (oldest < 0 || age[i] > oldest_age)) begin
            oldest     = i;
            oldest_age = age[i];
          end
        end
        res.evicted        = 1'b1;
        res.victim         = tag_mirror[oldest];
        tag_mirror[oldest] = page;
        make_recent(oldest);
        res.slot = SLOT_W'(oldest);
      end
    end
    return res;
  endfunction

  function automatic logic [PAGE_BITS-1:0] rand_page();
    return PAGE_BITS'({$urandom, $urandom});
  endfunction

  function automatic dir_result_t outcome(logic h, int unsigned s, logic e,
                                          logic [PAGE_BITS-1:0] v);
    dir_result_t r;
    r.hit     = h;
    r.slot    = SLOT_W'(s);
    r.evicted = e;
    r.victim  = v;
    return r;
  endfunction

  function automatic stim_row_t mk_access(logic act, logic [PAGE_BITS-1:0] page,
                                          logic fixed, dir_result_t want);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_ACCESS;
    r.act   = act;
    r.page  = page;
    r.fixed = fixed;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t mk_limit(logic [PDATA_W-1:0] wdata);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_LIMIT;
    r.wdata = wdata;
    return r;
  endfunction

  // Hold the input side idle for some cycles, with junk on the payload.
  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i    <= 1'b0;
      action_i      <= 1'($urandom_range(0, 1));
      page_number_i <= rand_page();
    end
  endtask

  // Offer one access and hold it until the block takes it; the expectation is
  // queued at the edge of acceptance.
  task automatic send_access(logic act, logic [PAGE_BITS-1:0] page, logic fixed,
                             dir_result_t want);
    dir_result_t predicted;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    action_i      <= act;
    page_number_i <= page;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_access(act, page);
    expected_q.push_back(fixed ? want : predicted);
  endtask

  // Bursts of random length separated by random gaps, unless the phase is gapless.
  task automatic pace(bit gapless);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!gapless) idle_cycles($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  task automatic wait_for_results();
    idle_cycles(1);
    while (expected_q.size() != 0) idle_cycles(1);
    idle_cycles(SETTLE_CYCLES);
  endtask

  // Write the slot limit once the block is idle, then read it back.
  task automatic write_limit(logic [PDATA_W-1:0] wdata);
    logic [PDATA_W-1:0] rd;
    wait_for_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SLOT_LIMIT;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    limit_mirror = wdata[LIMIT_W-1:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= $urandom;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    if (rd !== PDATA_W'(limit_mirror))
      report_mismatch("slot_limit readback", 64'(rd), 64'(limit_mirror));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Back-pressure on the result side, in a pattern that changes every so often.
  initial begin
    stall_mode_e mode;
    int unsigned span;
    out_stall_i = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE: begin
            out_stall_i <= 1'b0;
          end
          STALL_RANDOM: begin
            out_stall_i <= ($urandom_range(0, 2) == 0);
          end
          STALL_TOGGLE: begin
            out_stall_i <= ~out_stall_i;
          end
          default: begin
            out_stall_i <= ($urandom_range(0, 7) != 0);
          end
        endcase
      end
    end
  end

  // Every result taken by the receiver is held against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    dir_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", 64'({hit_o, slot_index_o}), 64'(0));
      end else begin
        want = expected_q.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", 64'(hit_o), 64'(want.hit));
        if (slot_index_o !== want.slot)
          report_mismatch("slot_index", 64'(slot_index_o), 64'(want.slot));
        if (evicted_o !== want.evicted)
          report_mismatch("evicted", 64'(evicted_o), 64'(want.evicted));
        if (evicted_page_o !== want.victim)
          report_mismatch("evicted_page", 64'(evicted_page_o), 64'(want.victim));
      end
    end
  end

  initial begin
    stim_row_t            plan [$];
    logic [PAGE_BITS-1:0] pool [$];
    logic [PAGE_BITS-1:0] pmax;
    logic [PAGE_BITS-1:0] page;
    logic                 act;
    int unsigned          phase_limits [11];
    int unsigned          phase_len;
    int unsigned          pool_size;
    int unsigned          pick;
    bit                   gapless;

    // Every input known from time zero, with reset held low before the directed table.
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACT_LOOKUP;
    page_number_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    burst_left    = 0;
    occupancy     = 0;
    limit_mirror  = LIMIT_RESET;
    for (int i = 0; i < int'(SLOTS); i++) begin
      tag_mirror[i] = '0;
      resident[i]   = 1'b0;
      age[i]        = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. Rows whose answer is plain from an empty directory carry it
    // typed in; the others go through the mirror.
    pmax = '1;
    plan.push_back(mk_access(ACT_LOOKUP, '0, 1'b1, outcome(0, 0, 0, '0)));
    plan.push_back(mk_access(ACT_LOOKUP, pmax, 1'b1, outcome(0, 0, 0, '0)));
    plan.push_back(mk_access(ACT_INSERT, '0, 1'b1, outcome(0, 0, 0, '0)));
    plan.push_back(mk_access(ACT_INSERT, pmax, 1'b1, outcome(0, 1, 0, '0)));
    plan.push_back(mk_access(ACT_INSERT, '0, 1'b1, outcome(1, 0, 0, '0)));
    plan.push_back(mk_access(ACT_LOOKUP, pmax, 1'b1, outcome(1, 1, 0, '0)));
    plan.push_back(mk_access(ACT_LOOKUP, 40'h55_5555_5555, 1'b1, outcome(0, 0, 0, '0)));
    // A limit equal to the use: every new page now replaces the least recent one.
    plan.push_back(mk_limit(32'h0000_0002));
    plan.push_back(mk_access(ACT_INSERT, 40'h55_5555_5555, 1'b0, '0));
    plan.push_back(mk_access(ACT_INSERT, 40'hAA_AAAA_AAAA, 1'b1, outcome(0, 1, 1, pmax)));
    plan.push_back(mk_access(ACT_LOOKUP, 40'h55_5555_5555, 1'b0, '0));
    // Low seven bits zero: a limit of nought, which acts as one and sits below the use.
    plan.push_back(mk_limit(32'hFFFF_FF80));
    plan.push_back(mk_access(ACT_INSERT, 40'h00_0000_0001, 1'b0, '0));
    plan.push_back(mk_access(ACT_INSERT, 40'h80_0000_0000, 1'b0, '0));
    plan.push_back(mk_access(ACT_LOOKUP, 40'h00_0000_0001, 1'b0, '0));
    // The widest limit value, which acts as the whole directory.
    plan.push_back(mk_limit(32'h0000_007F));
    plan.push_back(mk_access(ACT_INSERT, 40'h01_2345_6789, 1'b0, '0));
    plan.push_back(mk_access(ACT_INSERT, 40'hFE_DCBA_9876, 1'b0, '0));
    plan.push_back(mk_access(ACT_INSERT, 40'h00_0000_0001, 1'b0, '0));
    plan.push_back(mk_access(ACT_INSERT, 40'h80_0000_0000, 1'b0, '0));
    plan.push_back(mk_access(ACT_LOOKUP, 40'hFE_DCBA_9876, 1'b0, '0));
    // One above the slot count.
    plan.push_back(mk_limit(32'hFFFF_FFC1));
    plan.push_back(mk_access(ACT_INSERT, 40'h7F_7F7F_7F7F, 1'b0, '0));
    plan.push_back(mk_limit(32'h0000_0001));
    plan.push_back(mk_access(ACT_INSERT, 40'h0F_0F0F_0F0F, 1'b0, '0));
    plan.push_back(mk_access(ACT_INSERT, 40'hF0_F0F0_F0F0, 1'b0, '0));
    plan.push_back(mk_access(ACT_LOOKUP, 40'h0F_0F0F_0F0F, 1'b0, '0));
    plan.push_back(mk_limit(32'h0000_0040));
    plan.push_back(mk_access(ACT_INSERT, '0, 1'b0, '0));

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_LIMIT) begin
        write_limit(plan[r].wdata);
      end else begin
        send_access(plan[r].act, plan[r].page, plan[r].fixed, plan[r].want);
      end
    end

    // Random phases. Each picks a limit, then draws pages mostly from a pool larger
    // than the limit by between one and the limit plus two pages, so that hits, fills
    // and evictions all happen. The directory is never cleared between phases, so a
    // lowered limit finds it fuller than allowed.
    phase_limits = '{64, 1, 3, 127, 0, 8, 65, 2, 40, 5, 64};
    foreach (phase_limits[p]) begin
      write_limit(($urandom & ~PDATA_W'(32'h7F)) | PDATA_W'(phase_limits[p]));
      pool.delete();
      pool_size = effective_limit() + $urandom_range(1, effective_limit() + 2);
      repeat (pool_size) pool.push_back(rand_page());
      phase_len = (effective_limit() >= 32) ? 140 : 60;
      gapless   = (p % 3 == 2);
      burst_left = 0;
      for (int k = 0; k < int'(phase_len); k++) begin
        // Now and then the sender stops until the block has answered everything.
        if ((p == 0 && k == int'(phase_len / 2)) || $urandom_range(0, 199) == 0)
          wait_for_results();
        pace(gapless);
        act  = ($urandom_range(0, 99) < 55) ? ACT_INSERT : ACT_LOOKUP;
        pick = $urandom_range(0, 99);
        if (pick < 85) page = pool[$urandom_range(0, pool.size() - 1)];
        else if (pick < 92) page = rand_page();
        else if (pick < 96) page = '0;
        else page = '1;
        send_access(act, page, 1'b0, '0);
      end
    end

    // Drain: every expectation must be met within a bounded wait.
    idle_cycles(1);
    for (int n = 0; n < int'(DRAIN_CYCLES) && expected_q.size() != 0; n++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("results never delivered", 64'(expected_q.size()), 64'(0));
    if (mismatches == 0) begin
      $display("lru_page_cache_directory test passed");
    end else begin
      $display("lru_page_cache_directory test failed");
    end
    $finish;
  end

endmodule
